// ----- src/assert_macros.svh -----
// Assertion macros used by the IPv4 prefix filter datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every clock edge while out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication checked on every clock edge while out of reset.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)

`endif

`endif

// ----- src/ipfilt_pkg.sv -----
// Shared types, codes and a helper function of the IPv4 prefix filter.
`default_nettype none

package ipfilt_pkg;

    localparam int ALLOW_DEPTH_DEF = 8;
    localparam int BLOCK_DEPTH_DEF = 8;

    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 6;
    localparam int FUNC_W   = 3;
    localparam int RULE_W   = ADDR_W + LEN_W;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;

    localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

    localparam logic [FUNC_W-1:0] FN_CHECK     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD_ALLOW = 3'd1;
    localparam logic [FUNC_W-1:0] FN_ADD_BLOCK = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CLR_ALLOW = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLR_BLOCK = 3'd4;

    localparam logic [1:0] VERDICT_OK       = 2'd0;
    localparam logic [1:0] VERDICT_BLOCKED  = 2'd1;
    localparam logic [1:0] VERDICT_NO_ALLOW = 2'd2;

    typedef enum logic [2:0] {
        RES_NONE    = 3'd0,
        RES_PASS    = 3'd1,
        RES_BLOCKED = 3'd2,
        RES_NOMATCH = 3'd3,
        RES_FULL    = 3'd4
    } t_res;

    typedef struct packed {
        logic        load;
        logic        scan_start;
        logic        scan;
        logic        sel_allow;
        logic        wr_allow;
        logic        wr_block;
        logic        clr_allow;
        logic        clr_block;
        logic        res_we;
        t_res        res;
        logic        out_load;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              allow_full;
        logic              block_full;
        logic              allow_empty;
        logic              hit;
        logic              scan_end;
        logic              out_busy;
    } t_stat;

    // A length of zero gives an empty mask and 32 gives a full mask.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        prefix_mask = ~({ADDR_W{1'b1}} >> len);
    endfunction

endpackage

`default_nettype wire

// ----- src/ipfilt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ipfilt_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/ipfilt_ctrl.sv -----
// Controller state machine that sequences item decode, rule scans and result hand-off.
`default_nettype none

module ipfilt_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire ipfilt_pkg::t_stat i_stat,
    output ipfilt_pkg::t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_BSCAN = 5'b00100,
        ST_ASCAN = 5'b01000,
        ST_FIN   = 5'b10000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    ipfilt_pkg::t_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    cmd.load = 1'b1;
                    n_state  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.res_we = 1'b1;
                cmd.res    = ipfilt_pkg::RES_NONE;
                n_state    = ST_FIN;
                case (i_stat.func)
                    ipfilt_pkg::FN_CHECK: begin
                        cmd.res_we     = 1'b0;
                        cmd.scan_start = 1'b1;
                        cmd.sel_allow  = 1'b0;
                        n_state        = ST_BSCAN;
                    end
                    ipfilt_pkg::FN_ADD_ALLOW: begin
                        if (i_stat.allow_full) begin
                            cmd.res = ipfilt_pkg::RES_FULL;
                        end else begin
                            cmd.wr_allow = 1'b1;
                        end
                    end
                    ipfilt_pkg::FN_ADD_BLOCK: begin
                        if (i_stat.block_full) begin
                            cmd.res = ipfilt_pkg::RES_FULL;
                        end else begin
                            cmd.wr_block = 1'b1;
                        end
                    end
                    ipfilt_pkg::FN_CLR_ALLOW: begin
                        cmd.clr_allow = 1'b1;
                    end
                    ipfilt_pkg::FN_CLR_BLOCK: begin
                        cmd.clr_block = 1'b1;
                    end
                    default: begin
                        cmd.res = ipfilt_pkg::RES_NONE;
                    end
                endcase
            end
            ST_BSCAN: begin
                cmd.scan = 1'b1;
                if (i_stat.hit) begin
                    cmd.res_we = 1'b1;
                    cmd.res    = ipfilt_pkg::RES_BLOCKED;
                    n_state    = ST_FIN;
                end else if (i_stat.scan_end) begin
                    if (i_stat.allow_empty) begin
                        cmd.res_we = 1'b1;
                        cmd.res    = ipfilt_pkg::RES_PASS;
                        n_state    = ST_FIN;
                    end else begin
                        cmd.scan_start = 1'b1;
                        cmd.sel_allow  = 1'b1;
                        n_state        = ST_ASCAN;
                    end
                end
            end
            ST_ASCAN: begin
                cmd.scan = 1'b1;
                if (i_stat.hit) begin
                    cmd.res_we = 1'b1;
                    cmd.res    = ipfilt_pkg::RES_PASS;
                    n_state    = ST_FIN;
                end else if (i_stat.scan_end) begin
                    cmd.res_we = 1'b1;
                    cmd.res    = ipfilt_pkg::RES_NOMATCH;
                    n_state    = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!i_stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_cmd      = cmd;

endmodule

`default_nettype wire

// ----- src/ipfilt_dp.sv -----
// Datapath: item registers, rule stores, list counts, prefix compare and output register.
`default_nettype none

`include "assert_macros.svh"

module ipfilt_dp #(
    parameter int ALLOW_DEPTH = ipfilt_pkg::ALLOW_DEPTH_DEF,
    parameter int BLOCK_DEPTH = ipfilt_pkg::BLOCK_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [ipfilt_pkg::S_DATA_W-1:0]   i_s_tdata,
    input  wire logic [ipfilt_pkg::FUNC_W-1:0]     i_s_tuser,
    input  wire ipfilt_pkg::t_cmd                  i_cmd,
    output ipfilt_pkg::t_stat                      o_stat,
    output logic                                   o_m_tvalid,
    output logic      [ipfilt_pkg::M_DATA_W-1:0]   o_m_tdata,
    input  wire logic                              i_m_tready
);

    localparam int AW_W = ipfilt_pkg::ADDR_W;
    localparam int LN_W = ipfilt_pkg::LEN_W;
    localparam int RW   = ipfilt_pkg::RULE_W;
    localparam int AAW  = (ALLOW_DEPTH > 1) ? $clog2(ALLOW_DEPTH) : 1;
    localparam int BAW  = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
    localparam int ACW  = $clog2(ALLOW_DEPTH + 1);
    localparam int BCW  = $clog2(BLOCK_DEPTH + 1);
    localparam int IW   = (ACW > BCW) ? ACW : BCW;

    logic [ipfilt_pkg::FUNC_W-1:0]   r_func;
    logic [AW_W-1:0]                 r_addr;
    logic [LN_W-1:0]                 r_len;
    logic [ACW-1:0]                  r_allow_cnt;
    logic [BCW-1:0]                  r_block_cnt;
    logic [IW-1:0]                   r_idx;
    logic                            r_rvld;
    logic                            r_sel_allow;
    ipfilt_pkg::t_res                r_res;
    logic                            r_m_valid;
    logic [ipfilt_pkg::M_DATA_W-1:0] r_m_data;
    logic [ipfilt_pkg::M_DATA_W-1:0] n_m_data;

    logic [LN_W-1:0] in_len;
    logic [LN_W-1:0] in_len_sat;
    logic [IW-1:0]   cnt_sel;
    logic            issue;
    logic [RW-1:0]   allow_q;
    logic [RW-1:0]   block_q;
    logic [RW-1:0]   rule_q;
    logic [AW_W-1:0] rule_mask;
    logic            hit;
    logic            allow_full;
    logic            block_full;
    logic [1:0]      verdict;

    assign in_len     = i_s_tdata[AW_W +: LN_W];
    assign in_len_sat = (in_len > ipfilt_pkg::MAX_LEN) ? ipfilt_pkg::MAX_LEN : in_len;

    assign cnt_sel    = r_sel_allow ? IW'(r_allow_cnt) : IW'(r_block_cnt);
    assign issue      = i_cmd.scan && (r_idx < cnt_sel);
    assign rule_q     = r_sel_allow ? allow_q : block_q;
    assign rule_mask  = ipfilt_pkg::prefix_mask(rule_q[AW_W +: LN_W]);
    assign hit        = r_rvld && (((r_addr ^ rule_q[AW_W-1:0]) & rule_mask) == '0);
    assign allow_full = (r_allow_cnt == ACW'(ALLOW_DEPTH));
    assign block_full = (r_block_cnt == BCW'(BLOCK_DEPTH));

    ipfilt_ram #(
        .WIDTH(RW),
        .DEPTH(ALLOW_DEPTH)
    ) u_allow_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_allow),
        .i_waddr(r_allow_cnt[AAW-1:0]),
        .i_wdata({r_len, r_addr}),
        .i_raddr(r_idx[AAW-1:0]),
        .o_rdata(allow_q)
    );

    ipfilt_ram #(
        .WIDTH(RW),
        .DEPTH(BLOCK_DEPTH)
    ) u_block_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_block),
        .i_waddr(r_block_cnt[BAW-1:0]),
        .i_wdata({r_len, r_addr}),
        .i_raddr(r_idx[BAW-1:0]),
        .o_rdata(block_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_s_tuser;
            r_addr <= i_s_tdata[AW_W-1:0];
            r_len  <= in_len_sat;
        end
        if (i_cmd.scan_start) begin
            r_idx       <= '0;
            r_sel_allow <= i_cmd.sel_allow;
        end else if (issue) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.res_we) begin
            r_res <= i_cmd.res;
        end
        if (i_cmd.out_load) begin
            r_m_data <= n_m_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_cnt <= '0;
            r_block_cnt <= '0;
            r_rvld      <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            if (i_cmd.clr_allow) begin
                r_allow_cnt <= '0;
            end else if (i_cmd.wr_allow) begin
                r_allow_cnt <= r_allow_cnt + ACW'(1);
            end
            if (i_cmd.clr_block) begin
                r_block_cnt <= '0;
            end else if (i_cmd.wr_block) begin
                r_block_cnt <= r_block_cnt + BCW'(1);
            end
            r_rvld <= i_cmd.scan_start ? 1'b0 : issue;
            if (i_cmd.out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        case (r_res)
            ipfilt_pkg::RES_BLOCKED: verdict = ipfilt_pkg::VERDICT_BLOCKED;
            ipfilt_pkg::RES_NOMATCH: verdict = ipfilt_pkg::VERDICT_NO_ALLOW;
            default:                 verdict = ipfilt_pkg::VERDICT_OK;
        endcase
    end

    assign n_m_data = {4'b0000, (r_res == ipfilt_pkg::RES_FULL), verdict,
                       (r_res == ipfilt_pkg::RES_PASS)};

    assign o_stat.func        = r_func;
    assign o_stat.allow_full  = allow_full;
    assign o_stat.block_full  = block_full;
    assign o_stat.allow_empty = (r_allow_cnt == '0);
    assign o_stat.hit         = hit;
    assign o_stat.scan_end    = (r_idx == cnt_sel);
    assign o_stat.out_busy    = r_m_valid && !i_m_tready;

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    `ASSERT_IMPLY(a_no_write_full_allow, i_cmd.wr_allow, !allow_full, "Rule written to a full allow list")
    `ASSERT_IMPLY(a_no_write_full_block, i_cmd.wr_block, !block_full, "Rule written to a full block list")
    `ASSERT_IMPLY(a_scan_in_range, i_cmd.scan && !i_cmd.scan_start, r_idx <= cnt_sel, "Scan index ran past the list count")
    `ASSERT_IMPLY(a_out_free, i_cmd.out_load, !(r_m_valid && !i_m_tready), "Result loaded over a pending transfer")

endmodule

`default_nettype wire

// ----- src/ipv4_prefix_access_filter_unit.sv -----
// Top level of the IPv4 prefix access filter: controller plus datapath.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: address, pfx_len; tuser: func
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: allowed, verdict, status
//
// An add, a clear or an unused code writes its result in the execute state, then loads it out.
// A check scans the block list, then the allow list unless it is empty; a block hit ends the
// check at once, and each rule compared costs one RAM read and compare.
// The input is taken once the previous item has moved to the output register.
// A stalled output holds its result, and the next item then waits at the end.
// Reset clears both list counts; stored rules are not cleared.
`default_nettype none

module ipv4_prefix_access_filter_unit #(
    parameter int ALLOW_DEPTH = ipfilt_pkg::ALLOW_DEPTH_DEF,
    parameter int BLOCK_DEPTH = ipfilt_pkg::BLOCK_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [31:0] address, [37:32] pfx_len, [39:38] zero.
    input  wire logic [ipfilt_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [2:0] func.
    input  wire logic [ipfilt_pkg::FUNC_W-1:0]   s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [0] allowed, [2:1] verdict, [3] status, [7:4] zero.
    output logic      [ipfilt_pkg::M_DATA_W-1:0] m_axis_tdata
);

    ipfilt_pkg::t_cmd  cmd;
    ipfilt_pkg::t_stat stat;

    ipfilt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_axis_tvalid),
        .o_s_tready(s_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    ipfilt_dp #(
        .ALLOW_DEPTH(ALLOW_DEPTH),
        .BLOCK_DEPTH(BLOCK_DEPTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (s_axis_tdata),
        .i_s_tuser (s_axis_tuser),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .o_m_tvalid(m_axis_tvalid),
        .o_m_tdata (m_axis_tdata),
        .i_m_tready(m_axis_tready)
    );

endmodule

`default_nettype wire
